### sv/swpm_pkg.sv
// Package for the sliding window pair maximum block: field widths, the
// sequencer state type and the control bundle sent to the deque cells.
// No dependencies.
`default_nettype none

package swpm_pkg;

  localparam int unsigned DefaultDepth = 64;

  localparam int unsigned CoordW = 32;              // x and y fields
  localparam int unsigned ScoreW = CoordW + 1;      // y - x
  localparam int unsigned BestW  = CoordW + 3;      // y_i + y_j + x_j - x_i
  localparam int unsigned LimitW = 32;

  localparam int unsigned PaddrW = 2;
  localparam int unsigned PdataW = 32;

  // register byte address
  localparam logic [PaddrW-1:0] RegWindowLimit = 2'd0;

  typedef logic signed [CoordW-1:0] coord_t;
  typedef logic signed [ScoreW-1:0] score_t;
  typedef logic signed [BestW-1:0]  best_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FRONT,
    ST_PUSH
  } seq_state_t;

  // Commands broadcast to every cell of the deque.
  typedef struct packed {
    logic   clear;  // empty the deque
    logic   pop;    // drop the front entry, shift toward the front
    logic   push;   // drop dominated back entries and append
    logic   full;   // deque stays full after the back drop
    coord_t new_x;
    score_t new_s;
  } cell_ctl_t;

endpackage

`default_nettype wire

### sv/swpm_cell.sv
// One deque cell: holds one entry (x, y - x) and its valid bit, takes the
// entry of its back neighbor on a front pop and compares itself with the
// new point for the back drop. Depends on swpm_pkg.
`default_nettype none

module swpm_cell (
  input  wire                       clk,
  input  wire                       rst,
  input  wire swpm_pkg::cell_ctl_t  ctl,
  input  wire                       prev_keep,   // front neighbor survives the back drop
  input  wire                       next_valid,  // back neighbor entry
  input  wire swpm_pkg::coord_t     next_x,
  input  wire swpm_pkg::score_t     next_s,
  output logic                      valid,
  output swpm_pkg::coord_t          x,
  output swpm_pkg::score_t          score,
  output logic                      keep
);
  import swpm_pkg::*;

  logic dominated;

  // scores fall strictly front to back, so dominated cells form a suffix
  assign dominated = (ctl.new_s >= score);
  assign keep      = valid && !dominated;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctl.clear) begin
      valid <= 1'b0;
    end else if (ctl.pop) begin
      valid <= next_valid;
    end else if (ctl.push) begin
      if (ctl.full) begin
        valid <= 1'b1;
      end else if (prev_keep && !keep) begin
        valid <= 1'b1;
      end else begin
        valid <= keep;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.pop || (ctl.push && ctl.full)) begin
      x     <= next_x;
      score <= next_s;
    end else if (ctl.push && prev_keep && !keep) begin
      x     <= ctl.new_x;
      score <= ctl.new_s;
    end
  end

endmodule

`default_nettype wire

### sv/sliding_window_pair_max.sv
// Top level of the sliding window pair maximum: sequencer, running maximum,
// configuration port and the row of deque cells. Depends on swpm_pkg and
// swpm_cell.
//
// Takes points (x, y) and returns, for each point, the running maximum of
// y_i + y_j + (x_j - x_i) over pairs no more than window_limit apart in x,
// with a valid flag and a flag for a deque overflow. The deque is a row of
// WINDOW_DEPTH cells, front at cell 0. For each point the sequencer pops
// the front entries that fall out of the window, one entry per cycle,
// then scores the front, then drops dominated back entries and appends in
// a single cycle. The append waits while the previous result is still
// held in the output register. The result sits in an output register, so
// the next point is taken while it waits. window_limit is written at byte
// address 0 and reads back; write it only while no point is in flight.
`default_nettype none

module sliding_window_pair_max #(
  parameter int unsigned WINDOW_DEPTH = swpm_pkg::DefaultDepth
) (
  input  wire                          clk,
  input  wire                          rst,
  // point stream
  input  wire                          s_tvalid,
  output logic                         s_tready,
  input  wire  [63:0]                  s_tdata,   // [31:0] x_coord, [63:32] y_value
  input  wire  [0:0]                   s_tuser,   // [0] first_point
  // result stream
  output logic                         m_tvalid,
  input  wire                          m_tready,
  output logic [39:0]                  m_tdata,   // [34:0] best_value, rest zero
  output logic [1:0]                   m_tuser,   // [0] best_valid, [1] window_overflow
  // configuration
  input  wire                          psel,
  input  wire                          penable,
  input  wire                          pwrite,
  input  wire  [swpm_pkg::PaddrW-1:0]  paddr,
  input  wire  [swpm_pkg::PdataW-1:0]  pwdata,
  output logic [swpm_pkg::PdataW-1:0]  prdata,
  output logic                         pready
);
  import swpm_pkg::*;

  seq_state_t state, state_next;

  logic [LimitW-1:0] window_limit;
  coord_t            pt_x;
  coord_t            pt_y;
  best_t             running_best;
  logic              best_seen;
  best_t             out_best;
  logic              out_valid;
  logic              out_ovf;

  cell_ctl_t         ctl;
  logic              accept;
  logic              front_out;
  logic              out_free;
  logic signed [CoordW:0]   front_dist;
  logic signed [CoordW+1:0] limit_ext;
  best_t             cand;

  logic   cell_valid [WINDOW_DEPTH+1];
  coord_t cell_x     [WINDOW_DEPTH+1];
  score_t cell_s     [WINDOW_DEPTH+1];
  logic   cell_keep  [WINDOW_DEPTH];

  // configuration port
  assign pready = 1'b1;
  assign prdata = (paddr == RegWindowLimit) ? window_limit : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_limit <= '0;
    end else if (psel && penable && pwrite && pready) begin
      window_limit <= pwdata;
    end
  end

  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  // front entry check and score
  assign front_dist = {pt_x[CoordW-1], pt_x} - {cell_x[0][CoordW-1], cell_x[0]};
  assign limit_ext  = {2'b00, window_limit};
  assign front_out  = cell_valid[0] &&
                      ($signed({front_dist[CoordW], front_dist}) > limit_ext);
  assign cand = BestW'(pt_y) + BestW'(pt_x) + BestW'(cell_s[0]);

  // sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (accept) state_next = ST_FRONT;
      ST_FRONT: if (!front_out) state_next = ST_PUSH;
      ST_PUSH:  if (out_free) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    s_tready  = 1'b0;
    ctl.clear = 1'b0;
    ctl.pop   = 1'b0;
    ctl.push  = 1'b0;
    ctl.full  = cell_keep[WINDOW_DEPTH-1];
    ctl.new_x = pt_x;
    ctl.new_s = ScoreW'(pt_y) - ScoreW'(pt_x);
    unique case (state)
      ST_IDLE: begin
        s_tready  = 1'b1;
        ctl.clear = accept && s_tuser[0];
      end
      ST_FRONT: ctl.pop  = front_out;
      ST_PUSH:  ctl.push = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // hold the point while it is worked on
  always_ff @(posedge clk) begin
    if (accept) begin
      pt_x <= s_tdata[31:0];
      pt_y <= s_tdata[63:32];
    end
  end

  // running maximum
  always_ff @(posedge clk) begin
    if (rst) begin
      running_best <= '0;
      best_seen    <= 1'b0;
    end else if (ctl.clear) begin
      running_best <= '0;
      best_seen    <= 1'b0;
    end else if (state == ST_FRONT && cell_valid[0] && !front_out) begin
      if (!best_seen || cand > running_best) begin
        running_best <= cand;
        best_seen    <= 1'b1;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (ctl.push) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.push) begin
      out_best  <= running_best;
      out_valid <= best_seen;
      out_ovf   <= ctl.full;
    end
  end

  assign m_tdata = {5'd0, out_best};
  assign m_tuser = {out_ovf, out_valid};

  // row of cells; the slot past the back feeds the new point on a full push
  assign cell_valid[WINDOW_DEPTH] = 1'b0;
  assign cell_x[WINDOW_DEPTH]     = ctl.new_x;
  assign cell_s[WINDOW_DEPTH]     = ctl.new_s;

  for (genvar i = 0; i < WINDOW_DEPTH; i++) begin : g_cell
    logic prev_keep;
    if (i == 0) begin : g_head
      assign prev_keep = 1'b1;
    end else begin : g_body
      assign prev_keep = cell_keep[i-1];
    end

    swpm_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctl        (ctl),
      .prev_keep  (prev_keep),
      .next_valid (cell_valid[i+1]),
      .next_x     (cell_x[i+1]),
      .next_s     (cell_s[i+1]),
      .valid      (cell_valid[i]),
      .x          (cell_x[i]),
      .score      (cell_s[i]),
      .keep       (cell_keep[i])
    );
  end

endmodule

`default_nettype wire

### sv/swpm_checker.sv
// Port checker for sliding_window_pair_max, bound to the top level.
// Depends on swpm_pkg.
`default_nettype none

module swpm_checker (
  input wire                          clk,
  input wire                          rst,
  input wire                          s_tvalid,
  input wire                          s_tready,
  input wire                          m_tvalid,
  input wire                          m_tready,
  input wire [39:0]                   m_tdata,
  input wire [1:0]                    m_tuser,
  input wire                          pready
);
  import swpm_pkg::*;

  // one point at a time: no transfer right after a transfer
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("point taken while the previous one is in flight");

  // a result never comes out in the cycle after a transfer
  a_min_latency: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && !m_tvalid) |=> !m_tvalid)
    else $error("result appeared too early");

  // no valid pair means a zero maximum
  a_zero_best: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser[0]) |-> (m_tdata == 40'd0))
    else $error("best_value nonzero without a valid pair");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
    else $error("stalled result changed");

  a_pready: assert property (@(posedge clk) pready)
    else $error("pready low");

endmodule

bind sliding_window_pair_max swpm_checker u_swpm_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .pready   (pready)
);

`default_nettype wire

### sim/sliding_window_pair_max_test.sv
`timescale 1ns / 100ps
// Self-checking bench for sliding_window_pair_max: drives points on the input
// stream, tracks the deque in a local predictor and checks every result.
// Depends on swpm_pkg and the sliding_window_pair_max RTL.

module sliding_window_pair_max_test;
  import swpm_pkg::*;

  localparam int unsigned DEPTH = 64;
  localparam int unsigned PendDepth = 16;
  localparam coord_t CoordMin = {1'b1, {31{1'b0}}};
  localparam coord_t CoordMax = {1'b0, {31{1'b1}}};

  typedef struct {
    best_t value;
    logic  valid;
    logic  ovf;
  } pair_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic               s_tvalid = 1'b0;
  logic               s_tready;
  logic [63:0]        s_tdata = '0;   // [31:0] x_coord, [63:32] y_value
  logic [0:0]         s_tuser = '0;   // [0] first_point
  logic               m_tvalid;
  logic               m_tready = 1'b0;
  logic [39:0]        m_tdata;        // [34:0] best_value, rest zero
  logic [1:0]         m_tuser;        // [0] best_valid, [1] window_overflow
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [PaddrW-1:0]  paddr = '0;
  logic [PdataW-1:0]  pwdata = '0;
  logic [PdataW-1:0]  prdata;
  logic               pready;

  sliding_window_pair_max #(.WINDOW_DEPTH(DEPTH)) dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #10 clk = ~clk;

  // predictor copy of the deque and the running maximum
  longint        pt_x [DEPTH];
  longint        pt_gap [DEPTH];   // y - x
  int            dq_head;
  int            dq_count;
  longint        best_so_far;
  logic          best_found;
  logic [31:0]   limit_reg;

  // ring of expected results, written on input transfer, read on output transfer
  pair_result_t  pending_best [PendDepth];
  int            pend_wr = 0;
  int            pend_rd = 0;
  int            mismatch_count = 0;
  logic          tx_gaps_on = 1'b1;
  logic          rx_stall_on = 1'b1;
  int            rx_stall_left = 0;
  int            rx_draw;

  function automatic pair_result_t track_point(coord_t x_in, coord_t y_in, logic first);
    longint x, y, lim, cand;
    int b, t;
    pair_result_t r;
    x = x_in;
    y = y_in;
    lim = {32'd0, limit_reg};
    r.ovf = 1'b0;
    if (first) begin
      dq_head = 0;
      dq_count = 0;
      best_so_far = 0;
      best_found = 1'b0;
    end
    // drop front entries that fell out of the window
    while (dq_count > 0 && x - pt_x[dq_head] > lim) begin
      dq_head = (dq_head + 1) % DEPTH;
      dq_count--;
    end
    if (dq_count > 0) begin
      cand = y + x + pt_gap[dq_head];
      if (!best_found || cand > best_so_far) begin
        best_so_far = cand;
        best_found = 1'b1;
      end
    end
    // drop dominated back entries
    while (dq_count > 0) begin
      b = (dq_head + dq_count - 1) % DEPTH;
      if (y - x >= pt_gap[b]) dq_count--;
      else break;
    end
    if (dq_count >= DEPTH) begin
      dq_head = (dq_head + 1) % DEPTH;
      dq_count = DEPTH - 1;
      r.ovf = 1'b1;
    end
    t = (dq_head + dq_count) % DEPTH;
    pt_x[t] = x;
    pt_gap[t] = y - x;
    dq_count++;
    r.valid = best_found;
    r.value = best_found ? best_t'(best_so_far[BestW-1:0]) : '0;
    return r;
  endfunction

  // result side: draw a stall before each result
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      rx_stall_left <= 0;
    end else if (m_tvalid && m_tready) begin
      rx_draw = rx_stall_on ? $urandom_range(0, 3) : 0;
      rx_stall_left <= rx_draw;
      m_tready <= (rx_draw == 0);
    end else if (rx_stall_left > 0) begin
      rx_stall_left <= rx_stall_left - 1;
      m_tready <= (rx_stall_left == 1);
    end else begin
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    pair_result_t exp_r;
    if (!rst && m_tvalid && m_tready) begin
      if (pend_wr == pend_rd) begin
        $display("%0t unexpected result: best_value %0d valid %0b overflow %0b", $time,
                 $signed(m_tdata[BestW-1:0]), m_tuser[0], m_tuser[1]);
        mismatch_count++;
      end else begin
        exp_r = pending_best[pend_rd % PendDepth];
        pend_rd++;
        if (m_tdata[BestW-1:0] !== exp_r.value) begin
          $display("%0t best_value expected %0d got %0d", $time, exp_r.value,
                   $signed(m_tdata[BestW-1:0]));
          mismatch_count++;
        end
        if (m_tdata[39:BestW] !== '0) begin
          $display("%0t tdata padding expected 0 got %h", $time, m_tdata[39:BestW]);
          mismatch_count++;
        end
        if (m_tuser[0] !== exp_r.valid) begin
          $display("%0t best_valid expected %0b got %0b", $time, exp_r.valid, m_tuser[0]);
          mismatch_count++;
        end
        if (m_tuser[1] !== exp_r.ovf) begin
          $display("%0t window_overflow expected %0b got %0b", $time, exp_r.ovf, m_tuser[1]);
          mismatch_count++;
        end
      end
    end
  end

  task automatic send_point(input coord_t x, input coord_t y, input logic first);
    int gap;
    gap = tx_gaps_on ? $urandom_range(0, 3) : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {y, x};
    s_tuser <= first;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    pending_best[pend_wr % PendDepth] = track_point(x, y, first);
    pend_wr++;
  endtask

  // hold the input stream until every result is back
  task automatic wait_drain();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (pend_wr != pend_rd);
  endtask

  task automatic apb_access(input logic wr, input logic [31:0] wdata,
                            output logic [31:0] rdata);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= RegWindowLimit;
    pwdata <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rdata = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic check_limit(input logic [31:0] want);
    logic [31:0] got;
    apb_access(1'b0, '0, got);
    if (got !== want) begin
      $display("%0t window_limit readback expected %h got %h", $time, want, got);
      mismatch_count++;
    end
  endtask

  task automatic write_limit(input logic [31:0] lim);
    logic [31:0] unused;
    apb_access(1'b1, lim, unused);
    limit_reg = lim;
    check_limit(lim);
  endtask

  task automatic test_register_access();
    check_limit('0);
    write_limit(32'hAAAA_AAAA);
    write_limit(32'h5555_5555);
  endtask

  task automatic test_directed_points();
    write_limit(32'hFFFF_FFFF);
    send_point(CoordMin, CoordMin, 1'b1);
    send_point(CoordMin + 1, CoordMax, 1'b0);
    send_point(CoordMax, CoordMax, 1'b0);
    send_point(CoordMax, CoordMin, 1'b0);   // equal x
    send_point(0, 0, 1'b0);                 // x going back
    send_point(-1, -1, 1'b0);
    send_point(100, 5, 1'b1);               // clear mid-run
    send_point(101, 5, 1'b0);
    send_point(102, 4, 1'b0);               // ties the running best
    send_point(103, 3, 1'b0);
    wait_drain();
    write_limit('0);
    send_point(10, 3, 1'b1);
    send_point(11, 7, 1'b0);
    send_point(12, 1, 1'b0);
    send_point(12, 9, 1'b0);                // zero distance still pairs
    send_point(5, CoordMin, 1'b0);
    wait_drain();
    write_limit(32'd1);
    send_point(0, 0, 1'b1);
    send_point(1, 0, 1'b0);
    send_point(3, 0, 1'b0);
    send_point(4, CoordMax, 1'b0);
    wait_drain();
  endtask

  task automatic test_deque_overflow();
    write_limit(32'hFFFF_FFFF);
    // constant y with rising x keeps y - x falling, so nothing is dropped
    send_point(0, 0, 1'b1);
    for (int i = 1; i < 70; i++) send_point(i, 0, 1'b0);
    wait_drain();
    write_limit(32'd10);
    send_point(200, 5, 1'b0);               // whole deque ages out at once
    send_point(205, CoordMax, 1'b0);
    wait_drain();
  endtask

  task automatic test_paused_sender();
    write_limit(32'd50);
    tx_gaps_on = 1'b0;
    rx_stall_on = 1'b1;
    send_point(-20, 7, 1'b1);
    for (int i = 0; i < 8; i++) send_point(-19 + 3 * i, $urandom_range(0, 40), 1'b0);
    wait_drain();
    for (int i = 0; i < 8; i++) send_point(10 + 7 * i, $urandom_range(0, 40), 1'b0);
    wait_drain();
    tx_gaps_on = 1'b1;
  endtask

  task automatic test_random_points(input logic [31:0] lim, input int n_items,
                                    input int max_step);
    int sent, seq_left;
    longint xn;
    coord_t yv;
    logic first;
    wait_drain();
    write_limit(lim);
    tx_gaps_on = ($urandom_range(0, 3) != 0);
    rx_stall_on = ($urandom_range(0, 3) != 0);
    seq_left = 0;
    sent = 0;
    while (sent < n_items) begin
      first = 1'b0;
      if (seq_left == 0) begin
        seq_left = $urandom_range(1, 80);
        first = 1'b1;
        xn = $signed($urandom);
      end else if ($urandom_range(0, 15) == 0) begin
        xn = $signed($urandom);            // break the rising order
      end else begin
        xn = xn + $urandom_range(1, max_step);
      end
      if (xn > 64'sd2147483647) begin
        xn = $signed($urandom);
        first = 1'b1;
      end
      if ($urandom_range(0, 39) == 0) first = 1'b1;
      case ($urandom_range(0, 3))
        0: yv = $urandom;
        1: yv = $urandom_range(0, 100) - 50;
        2: yv = $urandom_range(0, 1) ? CoordMax : CoordMin;
        default: yv = coord_t'($urandom_range(0, 1 << 20));
      endcase
      send_point(coord_t'(xn[31:0]), yv, first);
      if ($urandom_range(0, 59) == 0) wait_drain();
      seq_left--;
      sent++;
    end
    wait_drain();
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    limit_reg = '0;
    dq_head = 0;
    dq_count = 0;
    best_so_far = 0;
    best_found = 1'b0;
    test_register_access();
    test_directed_points();
    test_deque_overflow();
    test_paused_sender();
    test_random_points(32'd16, 125, 8);
    test_random_points($urandom, 125, 1 << 24);
    test_random_points($urandom_range(0, 1000), 125, 300);
    test_random_points(32'hFFFF_FFFF, 125, 1 << 20);
    wait_drain();
    repeat (20) @(posedge clk);
    if (mismatch_count == 0 && pend_wr == pend_rd) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("FAIL");
    $finish;
  end

endmodule
